>>> sv/binary_image_border_tracer_defines.svh
// ----------------------------------------------------------------------------
// Binary image border tracer assertion macros
// Shared concurrent assertion forms for the border tracer RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_BORDER_TRACER_DEFINES_SVH
`define BINARY_IMAGE_BORDER_TRACER_DEFINES_SVH

// same-cycle implication
`define BIBT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bibt: same-cycle check failed");

// next-cycle implication
`define BIBT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bibt: next-cycle check failed");

`endif

>>> sv/bibt_pkg.sv
// ----------------------------------------------------------------------------
// Border tracer package
// Shared constants, codes, types and direction tables.
// ----------------------------------------------------------------------------
package bibt_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // border search phase
    localparam logic [1:0] PH_SCANNING = 2'd0;
    localparam logic [1:0] PH_TRACING  = 2'd1;
    localparam logic [1:0] PH_DONE     = 2'd2;

    // pixel codes held in the store
    localparam logic [1:0] PIX_BG  = 2'd0;
    localparam logic [1:0] PIX_FG  = 2'd1;
    localparam logic [1:0] PIX_TWO = 2'd2;
    localparam logic [1:0] PIX_NEG = 2'd3;

    // neighbor directions, clockwise from left
    localparam logic [2:0] DIR_LEFT  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_EIGHT  = 2'd2;

    localparam logic [9:0] RESET_DIM = 10'd512;

    typedef struct packed {
        logic       rd_go;
        logic       wr_en;
        logic       wr_last;
        logic [1:0] wr_data;
    } store_ctl_t;

    typedef struct packed {
        logic [8:0]  row;
        logic [8:0]  col;
        logic        last;
        logic [15:0] number;
        logic        none;
    } result_t;

    function automatic logic signed [1:0] dir_dr(input logic [2:0] e);
        logic signed [1:0] v;
        case (e)
            3'd1, 3'd2, 3'd3: v = -2'sd1;
            3'd5, 3'd6, 3'd7: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] dir_dc(input logic [2:0] e);
        logic signed [1:0] v;
        case (e)
            3'd0, 3'd1, 3'd7: v = -2'sd1;
            3'd3, 3'd4, 3'd5: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/bibt_in_if.sv
// ----------------------------------------------------------------------------
// Border tracer input channel
// Load and fetch items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bibt_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic pixel_value;

    modport source (output valid, output kind, output pixel_value, input ready);
    modport sink   (input valid, input kind, input pixel_value, output ready);
endinterface

>>> sv/bibt_out_if.sv
// ----------------------------------------------------------------------------
// Border tracer result channel
// Border pixel items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bibt_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  out_row;
    logic [8:0]  out_col;
    logic        last_of_border;
    logic [15:0] border_number;
    logic        no_more_borders;

    modport source (output valid, output out_row, output out_col, output last_of_border,
                    output border_number, output no_more_borders, input ready);
    modport sink   (input valid, input out_row, input out_col, input last_of_border,
                    input border_number, input no_more_borders, output ready);
endinterface

>>> sv/bibt_cfg_if.sv
// ----------------------------------------------------------------------------
// Border tracer configuration channel
// Register writes with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bibt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/binary_image_border_tracer.sv
// ----------------------------------------------------------------------------
// Binary image border tracer
// Loads a binary image and returns its borders one pixel per fetch.
// ----------------------------------------------------------------------------
// Channels: pixels takes items; kind 0 loads the next raster pixel, kind 1
// fetches the next border pixel. borders returns one item per fetch, none per
// load. cfg is always ready; it writes image_width (0), image_height (1) and
// eight_connected (2), which the user must do only while the block is idle;
// the block does not enforce this. A load restarts the border search at the
// first interior pixel. A fetch reads the pixel memory through a single port:
// each read passes the address multiply, the memory and then use. Following
// one border pixel takes up to nine reads; when a new border must be found,
// each raster pixel scanned adds one to three reads, each row end a step of
// its own, and the search for the second pixel up to seven more reads.
// One item is worked on at a time; pixels is ready whenever no fetch is in
// progress, so a load or fetch can enter while a result still waits.
// Reset sets the registers to 512 x 512, four-connected, load position zero
// and search at the start; the pixel memory is undefined until loaded.
// When borders stalls, a finished fetch holds in its final step until the
// output register frees; the output register holds its item until taken.
// ----------------------------------------------------------------------------
`include "binary_image_border_tracer_defines.svh"

module binary_image_border_tracer #(
    parameter int MAX_WIDTH  = bibt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bibt_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    bibt_in_if.sink     pixels,
    bibt_out_if.source  borders,
    bibt_cfg_if.sink    cfg
);

    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CWD = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SCAN     = 4'd1;
    localparam logic [3:0] ST_SCAN_V   = 4'd2;
    localparam logic [3:0] ST_SCAN_L   = 4'd3;
    localparam logic [3:0] ST_SCAN_R   = 4'd4;
    localparam logic [3:0] ST_SRCH     = 4'd5;
    localparam logic [3:0] ST_SRCH_CHK = 4'd6;
    localparam logic [3:0] ST_SELF     = 4'd7;
    localparam logic [3:0] ST_EMIT     = 4'd8;
    localparam logic [3:0] ST_WAIT     = 4'd9;

    logic [3:0]  state_reg, state_next, ret_reg, ret_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [RW-1:0]  scan_row_reg, scan_row_next, tr_reg, tr_next;
    logic [RW-1:0]  sr_reg, sr_next, sec_r_reg, sec_r_next;
    logic [CWD-1:0] scan_col_reg, scan_col_next, tc_reg, tc_next;
    logic [CWD-1:0] sc_reg, sc_next, sec_c_reg, sec_c_next;
    logic [2:0]  tdir_reg, tdir_next, srch_d_reg, srch_d_next, fdir_reg, fdir_next;
    logic [3:0]  k_reg, k_next;
    logic        cw_reg, cw_next, rz_reg, rz_next, fnd_reg, fnd_next;
    logic [AW-1:0] lp_reg, lp_next;
    logic [AW:0]   area;
    logic [9:0]  width_reg, width_next, height_reg, height_next;
    logic        eight_reg, eight_next;
    bibt_pkg::result_t pend_reg, pend_next, res_reg, res_next;
    logic        out_valid_reg, out_valid_next;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    bibt_pkg::store_ctl_t ctl;
    logic signed [RW+1:0]  rd_row, nb_r, nx_r;
    logic signed [CWD+1:0] rd_col, nb_c, nx_c;
    logic [AW-1:0] lp_use;
    logic [AW:0]   lp_inc;
    logic [1:0]  rd_data;
    logic [2:0]  e;
    logic        acc;
    logic        row_ok, col_bad, srch_end, last;
    logic [15:0] count_inc;
    logic        load_acc, scan_restart, tracing;

    bibt_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_row    (rd_row),
        .rd_col    (rd_col),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .load_addr (lp_use),
        .rd_data   (rd_data)
    );

    // clamp the configured dimensions
    always_comb
    begin
        if (width_reg < 10'd3)
            eff_w = WW'(3);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);
        if (height_reg < 10'd3)
            eff_h = HW'(3);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(height_reg);
    end

    assign area = (AW+1)'(eff_w) * (AW+1)'(eff_h);

    assign pixels.ready = (state_reg == ST_IDLE);
    assign acc          = pixels.valid && pixels.ready;
    assign cfg.ready    = 1'b1;

    assign load_acc     = acc && !pixels.kind;
    assign scan_restart = (phase_reg == bibt_pkg::PH_SCANNING) && (count_reg == 16'd1);
    assign tracing      = (phase_reg == bibt_pkg::PH_TRACING);

    assign borders.valid           = out_valid_reg;
    assign borders.out_row         = res_reg.row;
    assign borders.out_col         = res_reg.col;
    assign borders.last_of_border  = res_reg.last;
    assign borders.border_number   = res_reg.number;
    assign borders.no_more_borders = res_reg.none;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        eight_next  = eight_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                bibt_pkg::CFG_WIDTH:  width_next  = cfg.data;
                bibt_pkg::CFG_HEIGHT: height_next = cfg.data;
                bibt_pkg::CFG_EIGHT:  eight_next  = cfg.data[0];
                default: ;
            endcase
        end
    end

    // load position wraps at the image area
    always_comb
    begin
        lp_use = ((AW+1)'(lp_reg) >= area) ? '0 : lp_reg;
        lp_inc = (AW+1)'(lp_use) + (AW+1)'(1);
    end

    always_comb
    begin
        e        = cw_reg ? (srch_d_reg + k_reg[2:0]) : (srch_d_reg - k_reg[2:0]);
        srch_end = cw_reg ? k_reg[3] : (k_reg == 4'd9);
        nb_r     = $signed({2'b00, tr_reg}) + (RW+2)'(bibt_pkg::dir_dr(e));
        nb_c     = $signed({2'b00, tc_reg}) + (CWD+2)'(bibt_pkg::dir_dc(e));
        nx_r     = $signed({2'b00, tr_reg}) + (RW+2)'(bibt_pkg::dir_dr(fdir_reg));
        nx_c     = $signed({2'b00, tc_reg}) + (CWD+2)'(bibt_pkg::dir_dc(fdir_reg));
        row_ok   = (32'(scan_row_reg) + 32'd1) < 32'(eff_h);
        col_bad  = (scan_col_reg == '0) || ((32'(scan_col_reg) + 32'd1) >= 32'(eff_w));
        count_inc = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
        last     = !fnd_reg ||
                   ((nx_r[RW-1:0] == sr_reg) && (nx_c[CWD-1:0] == sc_reg) &&
                    (tr_reg == sec_r_reg) && (tc_reg == sec_c_reg));
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        tr_next       = tr_reg;
        tc_next       = tc_reg;
        sr_next       = sr_reg;
        sc_next       = sc_reg;
        sec_r_next    = sec_r_reg;
        sec_c_next    = sec_c_reg;
        tdir_next     = tdir_reg;
        srch_d_next   = srch_d_reg;
        fdir_next     = fdir_reg;
        k_next        = k_reg;
        cw_next       = cw_reg;
        rz_next       = rz_reg;
        fnd_next      = fnd_reg;
        lp_next       = lp_reg;
        pend_next     = pend_reg;
        ctl           = '0;
        rd_row        = nb_r;
        rd_col        = nb_c;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc && !pixels.kind)
                begin
                    ctl.wr_en     = 1'b1;
                    ctl.wr_data   = {1'b0, pixels.pixel_value};
                    lp_next       = (lp_inc >= area) ? '0 : lp_inc[AW-1:0];
                    phase_next    = bibt_pkg::PH_SCANNING;
                    scan_row_next = RW'(1);
                    scan_col_next = CWD'(1);
                    count_next    = 16'd1;
                end
                else if (acc)
                begin
                    case (phase_reg)
                        bibt_pkg::PH_TRACING:
                        begin
                            srch_d_next = tdir_reg;
                            k_next      = 4'd1;
                            cw_next     = 1'b0;
                            rz_next     = 1'b0;
                            state_next  = ST_SRCH;
                        end
                        bibt_pkg::PH_SCANNING:
                            state_next = ST_SCAN;
                        default:
                        begin
                            pend_next      = '0;
                            pend_next.none = 1'b1;
                            phase_next     = bibt_pkg::PH_DONE;
                            state_next     = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (!row_ok)
                begin
                    pend_next      = '0;
                    pend_next.none = 1'b1;
                    phase_next     = bibt_pkg::PH_DONE;
                    state_next     = ST_EMIT;
                end
                else if (col_bad)
                begin
                    scan_row_next = scan_row_reg + RW'(1);
                    scan_col_next = CWD'(1);
                end
                else
                begin
                    ctl.rd_go     = 1'b1;
                    rd_row        = $signed({2'b00, scan_row_reg});
                    rd_col        = $signed({2'b00, scan_col_reg});
                    tr_next       = scan_row_reg;
                    tc_next       = scan_col_reg;
                    scan_col_next = scan_col_reg + CWD'(1);
                    ret_next      = ST_SCAN_V;
                    state_next    = ST_WAIT;
                end
            end

            ST_SCAN_V:
            begin
                rd_row = $signed({2'b00, tr_reg});
                if (rd_data == bibt_pkg::PIX_FG)
                begin
                    ctl.rd_go  = 1'b1;
                    rd_col     = $signed({2'b00, tc_reg}) +
                                 (CWD+2)'(bibt_pkg::dir_dc(bibt_pkg::DIR_LEFT));
                    ret_next   = ST_SCAN_L;
                    state_next = ST_WAIT;
                end
                else if (rd_data == bibt_pkg::PIX_TWO)
                begin
                    ctl.rd_go  = 1'b1;
                    rd_col     = $signed({2'b00, tc_reg}) +
                                 (CWD+2)'(bibt_pkg::dir_dc(bibt_pkg::DIR_RIGHT));
                    ret_next   = ST_SCAN_R;
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN_L:
            begin
                rd_row = $signed({2'b00, tr_reg});
                if (rd_data == bibt_pkg::PIX_BG)
                begin
                    count_next  = count_inc;
                    srch_d_next = bibt_pkg::DIR_LEFT;
                    k_next      = 4'd1;
                    cw_next     = 1'b1;
                    state_next  = ST_SRCH;
                end
                else
                begin
                    ctl.rd_go  = 1'b1;
                    rd_col     = $signed({2'b00, tc_reg}) +
                                 (CWD+2)'(bibt_pkg::dir_dc(bibt_pkg::DIR_RIGHT));
                    ret_next   = ST_SCAN_R;
                    state_next = ST_WAIT;
                end
            end

            ST_SCAN_R:
            begin
                if (rd_data == bibt_pkg::PIX_BG)
                begin
                    count_next  = count_inc;
                    srch_d_next = bibt_pkg::DIR_RIGHT;
                    k_next      = 4'd1;
                    cw_next     = 1'b1;
                    state_next  = ST_SRCH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SRCH:
            begin
                if (srch_end)
                begin
                    if (cw_reg)
                    begin
                        // isolated pixel: a border of its own
                        pend_next.row    = 9'(tr_reg);
                        pend_next.col    = 9'(tc_reg);
                        pend_next.last   = 1'b1;
                        pend_next.number = count_reg;
                        pend_next.none   = 1'b0;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        fnd_next   = 1'b0;
                        ctl.rd_go  = 1'b1;
                        rd_row     = $signed({2'b00, tr_reg});
                        rd_col     = $signed({2'b00, tc_reg});
                        ret_next   = ST_SELF;
                        state_next = ST_WAIT;
                    end
                end
                else if (!eight_reg && e[0])
                begin
                    k_next = k_reg + 4'd1;
                end
                else
                begin
                    ctl.rd_go  = 1'b1;
                    ret_next   = ST_SRCH_CHK;
                    state_next = ST_WAIT;
                end
            end

            ST_SRCH_CHK:
            begin
                if (rd_data != bibt_pkg::PIX_BG)
                begin
                    if (cw_reg)
                    begin
                        // second pixel found: open the border and follow it
                        sr_next     = tr_reg;
                        sc_next     = tc_reg;
                        sec_r_next  = nb_r[RW-1:0];
                        sec_c_next  = nb_c[CWD-1:0];
                        tdir_next   = e;
                        srch_d_next = e;
                        phase_next  = bibt_pkg::PH_TRACING;
                        k_next      = 4'd1;
                        cw_next     = 1'b0;
                        rz_next     = 1'b0;
                        state_next  = ST_SRCH;
                    end
                    else
                    begin
                        fnd_next   = 1'b1;
                        fdir_next  = e;
                        ctl.rd_go  = 1'b1;
                        rd_row     = $signed({2'b00, tr_reg});
                        rd_col     = $signed({2'b00, tc_reg});
                        ret_next   = ST_SELF;
                        state_next = ST_WAIT;
                    end
                end
                else
                begin
                    if (!cw_reg && (e == bibt_pkg::DIR_RIGHT))
                        rz_next = 1'b1;
                    k_next     = k_reg + 4'd1;
                    state_next = ST_SRCH;
                end
            end

            ST_SELF:
            begin
                // mark the followed pixel at the address just read
                if (rz_reg)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_last = 1'b1;
                    ctl.wr_data = bibt_pkg::PIX_NEG;
                end
                else if (rd_data == bibt_pkg::PIX_FG)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_last = 1'b1;
                    ctl.wr_data = bibt_pkg::PIX_TWO;
                end
                pend_next.row    = 9'(tr_reg);
                pend_next.col    = 9'(tc_reg);
                pend_next.last   = last;
                pend_next.number = count_reg;
                pend_next.none   = 1'b0;
                if (last)
                begin
                    phase_next = bibt_pkg::PH_SCANNING;
                end
                else
                begin
                    tr_next   = nx_r[RW-1:0];
                    tc_next   = nx_c[CWD-1:0];
                    tdir_next = fdir_reg + 3'd4;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || borders.ready)
                    state_next = ST_IDLE;
            end

            ST_WAIT:
                state_next = ret_reg;

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (borders.ready)
            out_valid_next = 1'b0;
        if ((state_reg == ST_EMIT) && (!out_valid_reg || borders.ready))
        begin
            res_next       = pend_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            phase_reg     <= bibt_pkg::PH_SCANNING;
            count_reg     <= 16'd1;
            scan_row_reg  <= RW'(1);
            scan_col_reg  <= CWD'(1);
            tr_reg        <= '0;
            tc_reg        <= '0;
            sr_reg        <= '0;
            sc_reg        <= '0;
            sec_r_reg     <= '0;
            sec_c_reg     <= '0;
            tdir_reg      <= '0;
            srch_d_reg    <= '0;
            fdir_reg      <= '0;
            k_reg         <= '0;
            cw_reg        <= 1'b0;
            rz_reg        <= 1'b0;
            fnd_reg       <= 1'b0;
            lp_reg        <= '0;
            width_reg     <= bibt_pkg::RESET_DIM;
            height_reg    <= bibt_pkg::RESET_DIM;
            eight_reg     <= 1'b0;
            pend_reg      <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            tr_reg        <= tr_next;
            tc_reg        <= tc_next;
            sr_reg        <= sr_next;
            sc_reg        <= sc_next;
            sec_r_reg     <= sec_r_next;
            sec_c_reg     <= sec_c_next;
            tdir_reg      <= tdir_next;
            srch_d_reg    <= srch_d_next;
            fdir_reg      <= fdir_next;
            k_reg         <= k_next;
            cw_reg        <= cw_next;
            rz_reg        <= rz_next;
            fnd_reg       <= fnd_next;
            lp_reg        <= lp_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            eight_reg     <= eight_next;
            pend_reg      <= pend_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BIBT_ASSERT_NOW(a_trace_count, clk, rst_n, tracing, count_reg >= 16'd2)
    `BIBT_ASSERT_NEXT(a_load_restart, clk, rst_n, load_acc, scan_restart)
    `BIBT_ASSERT_NOW(a_rd_wr_excl, clk, rst_n, ctl.rd_go, !ctl.wr_en)
    `BIBT_ASSERT_NOW(a_scan_col, clk, rst_n, state_reg == ST_SCAN, scan_col_reg != '0)

endmodule

>>> sv/bibt_store.sv
// ----------------------------------------------------------------------------
// Border tracer pixel store
// 2-bit pixel memory with coordinate addressing; read data two cycles after go.
// ----------------------------------------------------------------------------
module bibt_store #(
    parameter int MAX_WIDTH  = bibt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bibt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bibt_pkg::store_ctl_t                  ctl,
    input  logic signed [$clog2(MAX_HEIGHT)+1:0]  rd_row,
    input  logic signed [$clog2(MAX_WIDTH)+1:0]   rd_col,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]        eff_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]       eff_h,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] load_addr,
    output logic [1:0]                            rd_data
);

    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CWD   = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int SW    = RW + WW + 1;

    logic [1:0]        mem [DEPTH];
    logic [AW-1:0]     addr_reg;
    logic [1:0]        q_reg;
    logic              in_reg;
    logic              in2_reg;
    logic              on_image;
    logic [RW+WW-1:0]  prod;
    logic [SW-1:0]     sum;
    logic [AW-1:0]     wr_addr;

    always_comb
    begin
        on_image = !rd_row[RW+1] && !rd_col[CWD+1] &&
                   (rd_row[RW:0] < (RW+1)'(eff_h)) && (rd_col[CWD:0] < (CWD+1)'(eff_w));
        prod     = (RW+WW)'(rd_row[RW-1:0]) * (RW+WW)'(eff_w);
        sum      = SW'(prod) + SW'(rd_col[CWD-1:0]);
    end

    assign wr_addr = ctl.wr_last ? addr_reg : load_addr;
    assign rd_data = in2_reg ? q_reg : bibt_pkg::PIX_BG;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_go)
        begin
            addr_reg <= sum[AW-1:0];
        end
        q_reg <= mem[addr_reg];
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= ctl.wr_data;
        end
    end

    // off-image neighbors read as background
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg  <= 1'b0;
            in2_reg <= 1'b0;
        end
        else
        begin
            if (ctl.rd_go)
            begin
                in_reg <= on_image;
            end
            in2_reg <= in_reg;
        end
    end

endmodule
